### rtl/sida_pkg.sv
package sida_pkg;

   localparam int VALUE_FIELD_BITS       = 32;
   localparam int CHAR_BITS              = 6;
   localparam int CHAR_TDATA_BITS        = 8;
   localparam int DEFAULT_VALUE_BITS     = 32;
   localparam int DEFAULT_DECIMAL_DIGITS = 10;
   localparam int BCD_BITS               = 4;

   typedef logic [CHAR_BITS-1:0] char_type;

   localparam char_type ASCII_ZERO  = char_type'(48);
   localparam char_type ASCII_MINUS = char_type'(45);

endpackage

### rtl/signed_int_to_decimal_ascii_unit.sv
// Channel   Dir  Word                                 Marks
// req_      in   tdata[31:0] value (two's complement)  -
// rsp_      out  tdata[5:0] character, [7:6] zero     tlast = final character of a number
//
// Sequence: the bit-serial double dabble loop (one magnitude bit per cycle)
// is followed by the character unloader, which sends a minus sign for a
// negative value and then one BCD digit per cycle while the output register
// is free (rsp_tready does not hold it), leading zeros dropped.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// Stalls: rsp_tready low holds the output register and the unloader; the next
// req word is taken as soon as the last character sits in the output register.
module signed_int_to_decimal_ascii_unit
   import sida_pkg::*;
#(
   parameter int VALUE_BITS     = DEFAULT_VALUE_BITS,
   parameter int DECIMAL_DIGITS = DEFAULT_DECIMAL_DIGITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [VALUE_FIELD_BITS-1:0]  req_tdata,   // [31:0] value
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [CHAR_TDATA_BITS-1:0]   rsp_tdata,   // [5:0] character, [7:6] zero
   output logic                         rsp_tlast
);

   localparam int BCD_W   = DECIMAL_DIGITS * BCD_BITS;
   localparam int BIT_W   = $clog2(VALUE_BITS);
   localparam int DIG_W   = $clog2(DECIMAL_DIGITS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DABBLE = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic                    neg_ff, neg_in;
   logic                    started_ff, started_in;
   logic [BIT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [DIG_W-1:0]        dig_left_ff, dig_left_in;
   logic                    out_valid_ff, out_valid_in;
   char_type                out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;

   logic [VALUE_BITS+VALUE_FIELD_BITS-1:0] value_wide;
   logic [VALUE_BITS-1:0]   value_cut;
   logic [BCD_W-1:0]        bcd_adj;
   logic [BCD_BITS-1:0]     top_digit;
   logic                    out_free;
   logic                    req_take;

   // Low VALUE_BITS of the word, zero-extended when the value is wider.
   assign value_wide = {{VALUE_BITS{1'b0}}, req_tdata};
   assign value_cut  = value_wide[VALUE_BITS-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign top_digit  = bcd_ff[BCD_W-1 -: BCD_BITS];

   // Add 3 to every digit of five or more ahead of the shift.
   always_comb begin
      bcd_adj = bcd_ff;
      for (int d = 0; d < DECIMAL_DIGITS; d++) begin
         if (bcd_ff[d*BCD_BITS +: BCD_BITS] >= BCD_BITS'(5)) begin
            bcd_adj[d*BCD_BITS +: BCD_BITS] =
               bcd_ff[d*BCD_BITS +: BCD_BITS] + BCD_BITS'(3);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_left_in  = dig_left_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // Take the magnitude in full width, so the most negative value
               // maps to 2^(VALUE_BITS-1).
               neg_in      = value_cut[VALUE_BITS-1];
               mag_in      = value_cut[VALUE_BITS-1] ?
                             (~value_cut + VALUE_BITS'(1)) : value_cut;
               bcd_in      = '0;
               bit_cnt_in  = BIT_W'(VALUE_BITS - 1);
               dig_left_in = DIG_W'(DECIMAL_DIGITS);
               started_in  = 1'b0;
               state_in    = ST_DABBLE;
            end
         end
         ST_DABBLE: begin
            // Shift one magnitude bit into the BCD accumulator; drop the
            // carry out of the top digit.
            {bcd_in, mag_in} = {bcd_adj[BCD_W-2:0], mag_ff, 1'b0};
            bit_cnt_in       = bit_cnt_ff - BIT_W'(1);
            if (bit_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (neg_ff) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_char_in  = ASCII_MINUS;
                  out_last_in  = 1'b0;
                  neg_in       = 1'b0;
               end
            end else if (!started_ff && top_digit == '0 && dig_left_ff != DIG_W'(1)) begin
               // Leading zero: drop it without a character.
               bcd_in      = {bcd_ff[BCD_W-BCD_BITS-1:0], {BCD_BITS{1'b0}}};
               dig_left_in = dig_left_ff - DIG_W'(1);
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ASCII_ZERO + char_type'(top_digit);
               out_last_in  = (dig_left_ff == DIG_W'(1));
               started_in   = 1'b1;
               bcd_in       = {bcd_ff[BCD_W-BCD_BITS-1:0], {BCD_BITS{1'b0}}};
               dig_left_in  = dig_left_ff - DIG_W'(1);
               if (dig_left_ff == DIG_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         started_ff   <= 1'b0;
         bit_cnt_ff   <= '0;
         dig_left_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         neg_ff       <= neg_in;
         started_ff   <= started_in;
         bit_cnt_ff   <= bit_cnt_in;
         dig_left_ff  <= dig_left_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(CHAR_TDATA_BITS-CHAR_BITS){1'b0}}, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   // A taken word always starts the dabble loop.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_DABBLE)
      else $error("accepted word did not start conversion");

   // Only a minus sign or a decimal digit leaves the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_char_ff == ASCII_MINUS) ||
                     (out_char_ff >= ASCII_ZERO && out_char_ff <= ASCII_ZERO + char_type'(9)))
      else $error("character out of range");

   // The minus sign never ends a number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_char_ff == ASCII_MINUS |-> !rsp_tlast)
      else $error("minus sign marked last");

   // Returning to idle means the last digit was just loaded.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && state_in == ST_IDLE |=> rsp_tvalid && rsp_tlast)
      else $error("left emit without a final character");

endmodule
